@@ sv/tbfa_pkg.sv @@
`default_nettype none

package tbfa_pkg;

  // Frame geometry; the averaging shift needs a power-of-two frame length
  localparam int FRAME_LEN   = 64;
  localparam int NUM_SLOTS   = 3;
  localparam int SAMPLE_W    = 16;
  localparam int POS_W       = $clog2(FRAME_LEN);
  localparam int SLOT_W      = 2;
  localparam int STORE_DEPTH = NUM_SLOTS * 2 * FRAME_LEN;
  localparam int ADDR_W      = SLOT_W + 1 + POS_W;
  localparam int SUM_W       = SAMPLE_W + POS_W;
  localparam int FRAME_SHIFT = POS_W;

  // Channel index inside a slot
  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  // Input word
  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } sample_t;

  // Result word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       ready_flag;
    logic                       overrun_out;
    logic                       frame_end;
  } result_t;

  // Input command codes
  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_PROCESS = 1'b1;

  // Datapath operations
  typedef enum logic [2:0] {
    DP_NOP,
    DP_CLEAR,
    DP_XCH_L,
    DP_XCH_R,
    DP_CAP_R,
    DP_SUM,
    DP_WRITE_AVG,
    DP_PROC_DONE
  } dp_op_e;

  // Controller to datapath command bundle
  typedef struct packed {
    dp_op_e            op;
    logic [ADDR_W-1:0] idx;
    logic              chan;
    logic              acc_clr;
    logic              acc_en;
    logic              load_in;
    logic              out_load;
  } dp_cmd_t;

endpackage

`default_nettype wire

@@ sv/tbfa_datapath.sv @@
`default_nettype none

module tbfa_datapath import tbfa_pkg::*; (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  dp_cmd_t cmd_i,
  input  sample_t in_data_i,
  output result_t out_data_o
);

  // Sample store: {slot, channel, position}
  logic signed [SAMPLE_W-1:0] mem_q [0:STORE_DEPTH-1];
  logic signed [SAMPLE_W-1:0] rdata_q;

  // Slot roles, position and flags
  logic [SLOT_W-1:0] fill_q, dump_q, ready_q;
  logic [POS_W-1:0]  pos_q;
  logic              frame_ready_q, overrun_q;

  // Payload registers
  logic signed [SAMPLE_W-1:0] left_q, right_q, lo_q, ro_q;
  logic                       fe_q;
  logic signed [SUM_W-1:0]    acc_q;
  result_t                    out_q;

  logic                       we;
  logic [ADDR_W-1:0]          waddr, raddr;
  logic signed [SAMPLE_W-1:0] wdata;
  logic signed [SUM_W-1:0]    acc_shr;
  logic                       pos_last;
  logic [POS_W-1:0]           idx_pos;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s >= SLOT_W'(NUM_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  assign pos_last = (pos_q == POS_W'(FRAME_LEN - 1));
  assign idx_pos  = cmd_i.idx[POS_W-1:0];
  assign acc_shr  = acc_q >>> FRAME_SHIFT;

  // Steer memory addresses and write data by operation
  always_comb begin
    we    = 1'b0;
    waddr = cmd_i.idx;
    raddr = {ready_q, cmd_i.chan, idx_pos};
    wdata = '0;
    case (cmd_i.op)
      DP_CLEAR: begin
        we    = 1'b1;
        waddr = cmd_i.idx;
        wdata = '0;
      end
      DP_XCH_L: begin
        we    = 1'b1;
        waddr = {fill_q, CH_LEFT, pos_q};
        wdata = left_q;
        raddr = {dump_q, CH_LEFT, pos_q};
      end
      DP_XCH_R: begin
        we    = 1'b1;
        waddr = {fill_q, CH_RIGHT, pos_q};
        wdata = right_q;
        raddr = {dump_q, CH_RIGHT, pos_q};
      end
      DP_SUM: begin
        raddr = {ready_q, cmd_i.chan, idx_pos};
      end
      DP_WRITE_AVG: begin
        we    = 1'b1;
        waddr = {ready_q, cmd_i.chan, idx_pos};
        wdata = acc_shr[SAMPLE_W-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Advance slot roles and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q        <= SLOT_W'(0);
      dump_q        <= SLOT_W'(1);
      ready_q       <= SLOT_W'(2);
      pos_q         <= '0;
      frame_ready_q <= 1'b0;
      overrun_q     <= 1'b0;
    end else begin
      case (cmd_i.op)
        DP_CAP_R: begin
          if (pos_last) begin
            pos_q         <= '0;
            ready_q       <= fill_q;
            fill_q        <= next_slot(fill_q);
            dump_q        <= next_slot(dump_q);
            overrun_q     <= overrun_q | frame_ready_q;
            frame_ready_q <= 1'b1;
          end else begin
            pos_q <= pos_q + POS_W'(1);
          end
        end
        DP_PROC_DONE: begin
          frame_ready_q <= 1'b0;
        end
        default: begin
          frame_ready_q <= frame_ready_q;
        end
      endcase
    end
  end

  // Capture input word, read-back samples and accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      left_q  <= in_data_i.left_in;
      right_q <= in_data_i.right_in;
    end
    if (cmd_i.op == DP_XCH_R) begin
      lo_q <= rdata_q;
    end
    if (cmd_i.op == DP_CAP_R) begin
      ro_q <= rdata_q;
      fe_q <= pos_last;
    end
    if (cmd_i.op == DP_PROC_DONE) begin
      lo_q <= '0;
      ro_q <= '0;
      fe_q <= 1'b0;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + {{(SUM_W - SAMPLE_W){rdata_q[SAMPLE_W-1]}}, rdata_q};
    end
    if (cmd_i.out_load) begin
      out_q.left_out    <= lo_q;
      out_q.right_out   <= ro_q;
      out_q.ready_flag  <= frame_ready_q;
      out_q.overrun_out <= overrun_q;
      out_q.frame_end   <= fe_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

@@ sv/tbfa_ctrl.sv @@
`default_nettype none

module tbfa_ctrl import tbfa_pkg::*; (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     in_valid_i,
  input  wire     in_cmd_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  wire     out_stall_i,
  output dp_cmd_t cmd_o
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_XCH_L    = 4'd2;
  localparam logic [3:0] S_XCH_R    = 4'd3;
  localparam logic [3:0] S_XCH_C    = 4'd4;
  localparam logic [3:0] S_SUM      = 4'd5;
  localparam logic [3:0] S_SUM_LAST = 4'd6;
  localparam logic [3:0] S_AVG      = 4'd7;
  localparam logic [3:0] S_PROC_END = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              chan_q, chan_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free, cnt_pos_last;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign cnt_pos_last = (cnt_q[POS_W-1:0] == POS_W'(FRAME_LEN - 1));

  // Sequence clear, exchange and averaging passes
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    chan_d         = chan_q;
    out_valid_d    = out_valid_q && out_stall_i;
    cmd_o          = '0;
    cmd_o.op       = DP_NOP;
    cmd_o.idx      = cnt_q;
    cmd_o.chan     = chan_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        cnt_d    = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d         = '0;
          chan_d        = CH_LEFT;
          state_d       = (in_cmd_i == CMD_PROCESS) ? S_SUM : S_XCH_L;
        end
      end
      S_XCH_L: begin
        cmd_o.op = DP_XCH_L;
        state_d  = S_XCH_R;
      end
      S_XCH_R: begin
        cmd_o.op = DP_XCH_R;
        state_d  = S_XCH_C;
      end
      S_XCH_C: begin
        cmd_o.op = DP_CAP_R;
        state_d  = S_FINISH;
      end
      S_SUM: begin
        cmd_o.op      = DP_SUM;
        cmd_o.acc_clr = (cnt_q == '0);
        cmd_o.acc_en  = (cnt_q != '0);
        if (cnt_pos_last) begin
          cnt_d   = '0;
          state_d = S_SUM_LAST;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      S_SUM_LAST: begin
        cmd_o.acc_en = 1'b1;
        state_d      = S_AVG;
      end
      S_AVG: begin
        cmd_o.op = DP_WRITE_AVG;
        if (cnt_pos_last) begin
          cnt_d = '0;
          if (chan_q == CH_RIGHT) begin
            state_d = S_PROC_END;
          end else begin
            chan_d  = CH_RIGHT;
            state_d = S_SUM;
          end
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      S_PROC_END: begin
        cmd_o.op = DP_PROC_DONE;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      chan_q      <= CH_LEFT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ sv/triple_buffer_frame_averager.sv @@
`default_nettype none

// Channel  Direction  Handshake            Word
// in       sink       in_valid_i/in_stall_o    sample_t (cmd, left_in, right_in)
// out      source     out_valid_o/out_stall_i  result_t (samples, flags, frame_end)
//
// A sample word passes the sample-store states S_XCH_L, S_XCH_R and S_XCH_C,
// then the output register load, which waits while a held result stalls.
// For a process word the store port walks each channel of the ready slot
// once to sum and once to write back.
// After reset a clearing pass zeroes all STORE_DEPTH words of the store;
// the input stalls until it ends.
// One word is in flight at a time; a new word is taken while a result waits.

module triple_buffer_frame_averager import tbfa_pkg::*; (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     in_valid_i,
  output logic    in_stall_o,
  input  sample_t in_data_i,
  output logic    out_valid_o,
  input  wire     out_stall_i,
  output result_t out_data_o
);

  dp_cmd_t dp_cmd;

  tbfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd)
  );

  tbfa_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  // One word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  // A completed frame always leaves a frame ready
  a_frame_end_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_end) |-> out_data_o.ready_flag)
    else $error("frame end without ready flag");

  // A new result only follows busy work
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an accepted word");

endmodule

`default_nettype wire
